FILE: design/frbc_pkg.sv
// ----------------------------------------------------------------------------
// frbc_pkg: shared types and constants of the frame rate boost controller
// Divider request and response words, timing constants and strength rounding.
// ----------------------------------------------------------------------------
package frbc_pkg;

  localparam int unsigned DivdW = 32;
  localparam int unsigned DivsW = 33;

  typedef struct packed {
    logic             start;
    logic [DivdW-1:0] dividend;
    logic [DivsW-1:0] divisor;
  } frbc_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivdW-1:0] quotient;
  } frbc_div_rsp_t;

  localparam logic [1:0] OP_PRESENT = 2'd0;
  localparam logic [1:0] OP_REPORT  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [2:0] CFG_ENABLE      = 3'd0;
  localparam logic [2:0] CFG_USER_TARGET = 3'd1;
  localparam logic [2:0] CFG_MARGIN      = 3'd2;
  localparam logic [2:0] CFG_BASE_PCT    = 3'd3;
  localparam logic [2:0] CFG_HOLD_MS     = 3'd4;
  localparam logic [2:0] CFG_GRADED      = 3'd5;
  localparam logic [2:0] CFG_PREFER      = 3'd6;
  localparam logic [2:0] CFG_FLOOR       = 3'd7;

  localparam logic [32:0] NS_DEFAULT_INTERVAL = 33'd16666666;
  localparam logic [63:0] NS_PRESENT_MAX_GAP  = 64'd100000000;
  localparam logic [63:0] NS_IDLE_TIMEOUT     = 64'd500000000;
  localparam logic [63:0] NS_MAX_INTERVAL     = 64'd5000000000;
  localparam logic [31:0] NS_PER_SEC          = 32'd1000000000;
  localparam logic [19:0] NS_PER_MS           = 20'd1000000;
  localparam logic [8:0]  TARGET_MAX          = 9'd300;
  localparam logic [31:0] WARMUP_SAMPLES      = 32'd8;
  localparam logic [6:0]  PCT_MIN             = 7'd5;
  localparam logic [6:0]  PCT_MAX             = 7'd100;
  localparam logic [31:0] FPS_SAT             = 32'd65535;

  // round up to a multiple of five (x/5 as x*205 >> 10), cap at 100
  function automatic logic [6:0] frbc_round_pct(input logic [7:0] pct);
    logic [8:0]  y;
    logic [16:0] p;
    logic [4:0]  q5;
    logic [7:0]  r;
    y  = {1'b0, pct} + 9'd4;
    p  = {8'b0, y} * 17'd205;
    q5 = p[14:10];
    r  = {3'b0, q5} * 8'd5;
    return (r > {1'b0, PCT_MAX}) ? PCT_MAX : r[6:0];
  endfunction

endpackage

FILE: design/frame_rate_boost_controller.sv
// ----------------------------------------------------------------------------
// frame_rate_boost_controller: frame cadence tracker and CPU boost decision
// Averages the frame interval from presents and reports and grades a boost
// percent on each control tick.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  word
//  s_axis    in   s_axis_tvalid/tready       event: tdata 168 b, tuser 3 b
//  m_axis    out  m_axis_tvalid/tready       decision: tdata 32 b
//  cfg       in   cfg_valid/cfg_ready        register index 3 b, data 14 b
//
//  Present and report words do not use the divider. A tick that is not idle or
//  cold runs one pass of the shared divider for the fps and may run a second
//  pass for the graded strength.
//  Reset clears all state at once; no clearing pass.
//  A new event is taken while the last decision waits in the output register;
//  the next decision holds until that register is free.
// ----------------------------------------------------------------------------
module frame_rate_boost_controller import frbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] now_ns, [85:64] source_pid, [149:86] report_interval_ns,
  // [161:150] report_target_fps, [167:162] zero
  input  logic [167:0] s_axis_tdata,
  // [1:0] opcode, [2] from_compositor
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] boost_on, [7:1] strength_pct, [8] floor_on, [24:9] measured_fps,
  // [31:25] zero
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [13:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PRES, S_REP, S_FEED0, S_FEED1, S_TICK0, S_TICK1, S_TDIV,
    S_TCMP, S_THOLD, S_GRADE, S_GDIV, S_GFIN, S_OUT
  } state_e;

  // configuration
  logic       enable_q, graded_q, prefer_q, floor_q;
  logic [8:0] user_target_q;
  logic [6:0] margin_q, base_q;
  logic [13:0] hold_ms_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      user_target_q <= 9'd60;
      margin_q      <= 7'd1;
      base_q        <= 7'd60;
      hold_ms_q     <= 14'd250;
      graded_q      <= 1'b1;
      prefer_q      <= 1'b1;
      floor_q       <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_ENABLE:      enable_q      <= cfg_data[0];
        CFG_USER_TARGET: user_target_q <= cfg_data[8:0];
        CFG_MARGIN:      margin_q      <= cfg_data[6:0];
        CFG_BASE_PCT:    base_q        <= cfg_data[6:0];
        CFG_HOLD_MS:     hold_ms_q     <= cfg_data;
        CFG_GRADED:      graded_q      <= cfg_data[0];
        CFG_PREFER:      prefer_q      <= cfg_data[0];
        CFG_FLOOR:       floor_q       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_e        state_q;
  frbc_div_req_t div_req_q;
  frbc_div_rsp_t div_rsp;

  logic [63:0] now_q, rep_int_q;
  logic [21:0] pid_q;
  logic [11:0] rep_tgt_q;

  logic [32:0] ema_q, last_interval_q;
  logic [31:0] sample_count_q;
  logic [21:0] tracked_pid_q;
  logic [8:0]  reported_target_q;
  logic [63:0] last_present_q, last_report_q, last_jank_q;
  logic        boosting_q;
  logic [6:0]  current_pct_q;
  logic [15:0] last_fps_q;

  logic [63:0] feed_x_q, act_q, sum_q;
  logic [33:0] hold_ns_q;
  logic [8:0]  tgt_q;
  logic [31:0] fps_q;
  logic        rel_q;
  logic        out_valid_q;
  logic [31:0] out_data_q;

  logic [64:0] pres_diff;
  logic        pres_later;
  logic [63:0] rep_gap, tick_gap, hold_d;
  logic        feed_bad;
  logic [32:0] li_d;
  logic [35:0] ema_sum;
  logic [32:0] ema_d;
  logic [8:0]  eff_tgt;
  logic [33:0] hold_ns_d;
  logic        jank, rel_d;
  logic [6:0]  base_c, room;
  logic        ungraded;
  logic [8:0]  deficit;
  logic [15:0] prod;
  logic [7:0]  pct_sum;
  logic        tick_idle, tick_cold, div_go;

  always_comb begin
    pres_diff  = {1'b0, now_q} - {1'b0, last_present_q};
    pres_later = ~pres_diff[64] && (pres_diff[63:0] != '0);
    rep_gap    = now_q - last_present_q;
    tick_gap   = now_q - act_q;
    hold_d     = sum_q - now_q;

    feed_bad = (feed_x_q == '0) || (feed_x_q > NS_MAX_INTERVAL);
    li_d     = feed_bad ? ((last_interval_q != '0) ? last_interval_q : NS_DEFAULT_INTERVAL)
                        : feed_x_q[32:0];
    ema_sum  = {3'b0, ema_q} + {2'b0, ema_q, 1'b0} + {3'b0, last_interval_q};
    ema_d    = (ema_q == '0) ? last_interval_q : ema_sum[34:2];

    eff_tgt   = (prefer_q && reported_target_q != '0 && reported_target_q <= TARGET_MAX)
                ? reported_target_q : user_target_q;
    hold_ns_d = {20'b0, hold_ms_q} * {14'b0, NS_PER_MS};

    jank  = ({1'b0, fps_q} + {26'b0, margin_q}) < {24'b0, tgt_q};
    rel_d = fps_q >= {22'b0, ({1'b0, tgt_q} + {3'b0, margin_q})};

    if (base_q < PCT_MIN)      base_c = PCT_MIN;
    else if (base_q > PCT_MAX) base_c = PCT_MAX;
    else                       base_c = base_q;
    room     = PCT_MAX - base_c;
    ungraded = !graded_q || (tgt_q == '0) || (fps_q >= {23'b0, tgt_q});
    deficit  = tgt_q - fps_q[8:0];
    prod     = {9'b0, room} * {7'b0, deficit};
    pct_sum  = {1'b0, base_c} + div_rsp.quotient[7:0];

    tick_idle = (act_q != '0) && (tick_gap > NS_IDLE_TIMEOUT);
    tick_cold = (ema_q == '0) || (sample_count_q < WARMUP_SAMPLES);
    div_go    = ((state_q == S_TICK1) && !tick_idle && !tick_cold) ||
                ((state_q == S_GRADE) && !ungraded);
  end

  frbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      div_req_q         <= '0;
      now_q             <= '0;
      rep_int_q         <= '0;
      pid_q             <= '0;
      rep_tgt_q         <= '0;
      ema_q             <= '0;
      last_interval_q   <= '0;
      sample_count_q    <= '0;
      tracked_pid_q     <= '0;
      reported_target_q <= '0;
      last_present_q    <= '0;
      last_report_q     <= '0;
      last_jank_q       <= '0;
      boosting_q        <= 1'b0;
      current_pct_q     <= '0;
      last_fps_q        <= '0;
      feed_x_q          <= '0;
      act_q             <= '0;
      sum_q             <= '0;
      hold_ns_q         <= '0;
      tgt_q             <= '0;
      fps_q             <= '0;
      rel_q             <= 1'b0;
      out_valid_q       <= 1'b0;
      out_data_q        <= '0;
    end else begin
      div_req_q.start <= div_go;
      if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            now_q     <= s_axis_tdata[63:0];
            pid_q     <= s_axis_tdata[85:64];
            rep_int_q <= s_axis_tdata[149:86];
            rep_tgt_q <= s_axis_tdata[161:150];
            case (s_axis_tuser[1:0])
              OP_PRESENT: state_q <= enable_q ? S_PRES : S_OUT;
              OP_REPORT:  state_q <= (enable_q && !s_axis_tuser[2]) ? S_REP : S_OUT;
              OP_TICK:    state_q <= S_TICK0;
              default:    state_q <= S_OUT;
            endcase
          end
        end
        S_PRES: begin
          last_present_q <= now_q;
          if (last_present_q != '0 && pres_later) begin
            feed_x_q <= pres_diff[63:0];
            state_q  <= (pres_diff[63:0] <= NS_PRESENT_MAX_GAP) ? S_FEED0 : S_OUT;
          end else begin
            feed_x_q <= '0;
            state_q  <= S_FEED0;
          end
        end
        S_REP: begin
          if (rep_tgt_q != '0 && rep_tgt_q <= {3'b0, TARGET_MAX}) begin
            reported_target_q <= rep_tgt_q[8:0];
          end
          if (tracked_pid_q != pid_q) begin
            tracked_pid_q   <= pid_q;
            last_interval_q <= '0;
            ema_q           <= '0;
            sample_count_q  <= '0;
          end
          last_report_q <= now_q;
          feed_x_q      <= rep_int_q;
          state_q <= (last_present_q == '0 || rep_gap > NS_IDLE_TIMEOUT) ? S_FEED0 : S_OUT;
        end
        S_FEED0: begin
          last_interval_q <= li_d;
          state_q         <= S_FEED1;
        end
        S_FEED1: begin
          ema_q <= ema_d;
          if (sample_count_q != '1) begin
            sample_count_q <= sample_count_q + 32'd1;
          end
          state_q <= S_OUT;
        end
        S_TICK0: begin
          act_q <= (last_present_q > last_report_q) ? last_present_q : last_report_q;
          if (!enable_q) begin
            boosting_q    <= 1'b0;
            current_pct_q <= '0;
            last_fps_q    <= '0;
            state_q       <= S_OUT;
          end else begin
            state_q <= S_TICK1;
          end
        end
        S_TICK1: begin
          tgt_q     <= eff_tgt;
          hold_ns_q <= hold_ns_d;
          if (tick_idle) begin
            last_interval_q <= '0;
            ema_q           <= '0;
            sample_count_q  <= '0;
            boosting_q      <= 1'b0;
            current_pct_q   <= '0;
            last_fps_q      <= '0;
            state_q         <= S_OUT;
          end else if (tick_cold) begin
            boosting_q    <= 1'b0;
            current_pct_q <= '0;
            last_fps_q    <= '0;
            state_q       <= S_OUT;
          end else begin
            div_req_q.dividend <= NS_PER_SEC;
            div_req_q.divisor  <= ema_q;
            state_q            <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_rsp.done) begin
            fps_q      <= div_rsp.quotient;
            last_fps_q <= (div_rsp.quotient > FPS_SAT) ? FPS_SAT[15:0]
                                                       : div_rsp.quotient[15:0];
            state_q    <= S_TCMP;
          end
        end
        S_TCMP: begin
          rel_q <= rel_d;
          sum_q <= last_jank_q + {30'b0, hold_ns_q};
          if (jank) begin
            last_jank_q <= now_q;
            boosting_q  <= 1'b1;
            state_q     <= S_GRADE;
          end else if (boosting_q) begin
            state_q <= S_THOLD;
          end else begin
            current_pct_q <= '0;
            state_q       <= S_OUT;
          end
        end
        S_THOLD: begin
          if (rel_q && hold_d[63]) begin
            boosting_q    <= 1'b0;
            current_pct_q <= '0;
            state_q       <= S_OUT;
          end else begin
            boosting_q <= 1'b1;
            state_q    <= S_GRADE;
          end
        end
        S_GRADE: begin
          if (ungraded) begin
            current_pct_q <= base_c;
            state_q       <= S_OUT;
          end else begin
            div_req_q.dividend <= {16'b0, prod};
            div_req_q.divisor  <= {24'b0, tgt_q};
            state_q            <= S_GDIV;
          end
        end
        S_GDIV: begin
          if (div_rsp.done) begin
            state_q <= S_GFIN;
          end
        end
        S_GFIN: begin
          current_pct_q <= frbc_round_pct(pct_sum);
          state_q       <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {7'b0, last_fps_q, boosting_q & floor_q, current_pct_q,
                            boosting_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pct_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !boosting_q |-> current_pct_q == '0)
    else $error("strength set while not boosting");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (boosting_q && state_q == S_IDLE) |->
      (current_pct_q >= PCT_MIN && current_pct_q <= PCT_MAX))
    else $error("strength out of range while boosting");

  a_cadence_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_count_q == '0) == (ema_q == '0))
    else $error("sample count and average disagree");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_TDIV || state_q == S_GDIV))
    else $error("divider result not awaited");
`endif

endmodule

FILE: design/frbc_div.sv
// ----------------------------------------------------------------------------
// frbc_div: shared restoring divider
// One quotient bit a cycle; a start word loads the operands, done pulses once.
// ----------------------------------------------------------------------------
module frbc_div import frbc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  frbc_div_req_t req_i,
  output frbc_div_rsp_t rsp_o
);

  localparam logic [4:0] LastStep = 5'(DivdW - 1);

  logic             busy_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [DivsW-1:0] rem_q;
  logic [DivdW-1:0] quo_q;
  logic [DivsW-1:0] dvs_q;

  logic [DivsW:0]   shifted;
  logic [DivsW+1:0] trial;
  logic             fits;
  logic [DivsW-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[DivdW-1]};
    trial   = {1'b0, shifted} - {2'b0, dvs_q};
    fits    = ~trial[DivsW+1];
    rem_d   = fits ? trial[DivsW-1:0] : shifted[DivsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DivdW-2:0], fits};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the frame rate boost controller
// Drives presents, frame reports and ticks with random stalls on both streams,
// predicts every decision word in a scoreboard and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import frbc_pkg::*;

  localparam logic [1:0]  OP_NONE     = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PARK_CYCLES = 300;
  localparam int unsigned NUM_PHASES  = 7;
  localparam logic [63:0] T0          = 64'd1000000000;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] at_ns;
    logic [21:0] pid;
    logic [63:0] iv_ns;
    logic [11:0] tgt_fps;
    logic        comp;
  } frame_evt_t;

  typedef struct packed {
    logic        en;
    logic [8:0]  user_tgt;
    logic [6:0]  margin;
    logic [6:0]  base;
    logic [13:0] hold;
    logic        graded;
    logic        prefer;
    logic        floor_allow;
  } boost_settings_t;

  class boost_scoreboard;
    boost_settings_t cfg;
    logic [63:0]     ema_ns, last_iv_ns;
    logic [31:0]     samples;
    logic [21:0]     tracked_pid;
    logic [8:0]      rep_tgt;
    logic [63:0]     t_present, t_report, t_jank;
    logic            boosting;
    logic [6:0]      strength;
    logic [15:0]     fps_seen;
    logic [31:0]     pending_decisions[$];
    int unsigned     errors;
    int unsigned     checked;

    function new();
      cfg = '{en: 1'b0, user_tgt: 9'd60, margin: 7'd1, base: 7'd60, hold: 14'd250,
              graded: 1'b1, prefer: 1'b1, floor_allow: 1'b1};
      ema_ns = '0; last_iv_ns = '0; samples = '0; tracked_pid = '0; rep_tgt = '0;
      t_present = '0; t_report = '0; t_jank = '0;
      boosting = 1'b0; strength = '0; fps_seen = '0;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [13:0] val);
      case (idx)
        CFG_ENABLE:      cfg.en          = val[0];
        CFG_USER_TARGET: cfg.user_tgt    = val[8:0];
        CFG_MARGIN:      cfg.margin      = val[6:0];
        CFG_BASE_PCT:    cfg.base        = val[6:0];
        CFG_HOLD_MS:     cfg.hold        = val;
        CFG_GRADED:      cfg.graded      = val[0];
        CFG_PREFER:      cfg.prefer      = val[0];
        CFG_FLOOR:       cfg.floor_allow = val[0];
        default: ;
      endcase
    endfunction

    function void feed_interval(logic [63:0] x);
      if (x == 0 || x > NS_MAX_INTERVAL)
        x = (last_iv_ns != 0) ? last_iv_ns : 64'(NS_DEFAULT_INTERVAL);
      last_iv_ns = x;
      ema_ns = (ema_ns == 0) ? x : (ema_ns * 64'd3 + x) >> 2;
      if (samples != 32'hFFFF_FFFF)
        samples++;
    endfunction

    function void clear_cadence();
      last_iv_ns = '0;
      ema_ns = '0;
      samples = '0;
    endfunction

    function void note_event(frame_evt_t e);
      logic [63:0] target, fps, activity, d, b, p;
      longint      f, tg, mg;
      logic        want;
      logic [31:0] word;
      case (e.op)
        OP_PRESENT: begin
          if (cfg.en) begin
            if (t_present != 0 && e.at_ns > t_present) begin
              if (e.at_ns - t_present <= NS_PRESENT_MAX_GAP)
                feed_interval(e.at_ns - t_present);
            end else begin
              feed_interval('0);
            end
            t_present = e.at_ns;
          end
        end
        OP_REPORT: begin
          if (cfg.en && !e.comp) begin
            if (e.tgt_fps >= 1 && e.tgt_fps <= TARGET_MAX)
              rep_tgt = e.tgt_fps[8:0];
            if (tracked_pid != e.pid) begin
              tracked_pid = e.pid;
              clear_cadence();
            end
            if (t_present == 0 || e.at_ns - t_present > NS_IDLE_TIMEOUT)
              feed_interval(e.iv_ns);
            t_report = e.at_ns;
          end
        end
        OP_TICK: begin
          target = (cfg.prefer && rep_tgt >= 1 && rep_tgt <= TARGET_MAX) ?
                   64'(rep_tgt) : 64'(cfg.user_tgt);
          fps = '0;
          activity = (t_present > t_report) ? t_present : t_report;
          want = 1'b0;
          if (!cfg.en) begin
            want = 1'b0;
          end else if (activity != 0 && e.at_ns - activity > NS_IDLE_TIMEOUT) begin
            clear_cadence();
          end else if (ema_ns == 0 || samples < WARMUP_SAMPLES) begin
            want = 1'b0;
          end else begin
            fps = 64'(NS_PER_SEC) / ema_ns;
            f  = longint'(fps);
            tg = longint'(target);
            mg = longint'(cfg.margin);
            if (f < tg - mg) begin
              want = 1'b1;
              t_jank = e.at_ns;
            end else if (boosting) begin
              d = t_jank + 64'(cfg.hold) * 64'(NS_PER_MS) - e.at_ns;
              want = !(f >= tg + mg && d[63]);
            end
          end
          b = 64'(cfg.base);
          if (b < PCT_MIN) b = 64'(PCT_MIN);
          if (b > PCT_MAX) b = 64'(PCT_MAX);
          if (!cfg.graded || target == 0 || fps >= target) begin
            p = b;
          end else begin
            p = b + ((64'd100 - b) * (target - fps)) / target;
            p = ((p + 64'd4) / 64'd5) * 64'd5;
            if (p > PCT_MAX) p = 64'(PCT_MAX);
          end
          boosting = want;
          strength = want ? p[6:0] : '0;
          fps_seen = (fps > FPS_SAT) ? 16'hFFFF : fps[15:0];
        end
        default: ;
      endcase
      word = '0;
      word[0]    = boosting;
      word[7:1]  = strength;
      word[8]    = boosting & cfg.floor_allow;
      word[24:9] = fps_seen;
      pending_decisions.push_back(word);
    endfunction

    function void check_decision(logic [31:0] got);
      logic [31:0] want;
      if (pending_decisions.size() == 0) begin
        if (errors < 10)
          $display("unexpected decision word %h", got);
        errors++;
        return;
      end
      want = pending_decisions.pop_front();
      if (got[0] !== want[0] || got[7:1] !== want[7:1] || got[8] !== want[8] ||
          got[24:9] !== want[24:9] || got[31:25] !== want[31:25]) begin
        if (errors < 10)
          $display("decision %0d: boost %b/%b strength %0d/%0d floor %b/%b fps %0d/%0d pad %h/%h",
                   checked, want[0], got[0], want[7:1], got[7:1], want[8], got[8],
                   want[24:9], got[24:9], want[31:25], got[31:25]);
        errors++;
      end
      checked++;
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_addr;
  logic [13:0]  cfg_data;

  boost_scoreboard sb = new();
  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  bit park_sink    = 1'b0;

  frame_rate_boost_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    frame_evt_t e;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready)
        sb.set_reg(cfg_addr, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        e.op      = s_axis_tuser[1:0];
        e.comp    = s_axis_tuser[2];
        e.at_ns   = s_axis_tdata[63:0];
        e.pid     = s_axis_tdata[85:64];
        e.iv_ns   = s_axis_tdata[149:86];
        e.tgt_fps = s_axis_tdata[161:150];
        sb.note_event(e);
      end
      if (m_axis_tvalid && m_axis_tready)
        sb.check_decision(m_axis_tdata);
    end
  end

  function automatic frame_evt_t random_event(logic [1:0] op, logic [63:0] at);
    frame_evt_t e;
    e.op      = op;
    e.at_ns   = at;
    e.pid     = 22'($urandom);
    e.iv_ns   = {$urandom, $urandom};
    e.tgt_fps = 12'($urandom);
    e.comp    = 1'($urandom);
    return e;
  endfunction

  task automatic send_event(input frame_evt_t e);
    int unsigned pause;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      pause = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, e.tgt_fps, e.iv_ns, e.pid, e.at_ns};
    s_axis_tuser  <= {e.comp, e.op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_settings(input boost_settings_t c);
    write_reg(CFG_ENABLE, 14'(c.en));
    write_reg(CFG_USER_TARGET, 14'(c.user_tgt));
    write_reg(CFG_MARGIN, 14'(c.margin));
    write_reg(CFG_BASE_PCT, 14'(c.base));
    write_reg(CFG_HOLD_MS, c.hold);
    write_reg(CFG_GRADED, 14'(c.graded));
    write_reg(CFG_PREFER, 14'(c.prefer));
    write_reg(CFG_FLOOR, 14'(c.floor_allow));
    cfg_valid <= 1'b0;
  endtask

  initial begin : sink
    int unsigned hold_off;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (park_sink) begin
        m_axis_tready <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk_i);
        park_sink = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        hold_off = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("stalled for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    boost_settings_t phase_cfg[NUM_PHASES];
    int unsigned     phase_items[NUM_PHASES];
    frame_evt_t      e;
    logic [63:0]     clock_ns, gap;
    logic [21:0]     app_pid;
    int unsigned     sent, kind, len, roll;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid     <= 1'b0;
    cfg_addr      <= CFG_ENABLE;
    cfg_data      <= '0;

    phase_cfg[0] = '{en: 1'b1, user_tgt: 9'd60, margin: 7'd1, base: 7'd60, hold: 14'd250,
                     graded: 1'b1, prefer: 1'b1, floor_allow: 1'b1};
    phase_cfg[1] = '{en: 1'b1, user_tgt: 9'd511, margin: 7'd0, base: 7'd0, hold: 14'd10,
                     graded: 1'b1, prefer: 1'b0, floor_allow: 1'b0};
    phase_cfg[2] = '{en: 1'b1, user_tgt: 9'd0, margin: 7'd127, base: 7'd127,
                     hold: 14'd16383, graded: 1'b0, prefer: 1'b1, floor_allow: 1'b1};
    phase_cfg[3] = '{en: 1'b0, user_tgt: 9'd60, margin: 7'd1, base: 7'd60, hold: 14'd250,
                     graded: 1'b1, prefer: 1'b1, floor_allow: 1'b1};
    phase_cfg[4] = '{en: 1'b1, user_tgt: 9'd1, margin: 7'd120, base: 7'd5,
                     hold: 14'd10000, graded: 1'b1, prefer: 1'b0, floor_allow: 1'b1};
    phase_cfg[5] = '{en: 1'b1, user_tgt: 9'd300, margin: 7'd10, base: 7'd100,
                     hold: 14'd100, graded: 1'b1, prefer: 1'b1, floor_allow: 1'b0};
    phase_cfg[6] = '{en: 1'b1, user_tgt: 9'($urandom_range(1, 300)),
                     margin: 7'($urandom_range(0, 8)), base: 7'($urandom_range(5, 100)),
                     hold: 14'($urandom_range(10, 2000)), graded: 1'b1,
                     prefer: 1'($urandom), floor_allow: 1'b1};
    phase_items = '{280, 280, 280, 40, 260, 260, 280};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // enable still off after reset: events leave everything untouched
    send_event(random_event(OP_PRESENT, T0));
    send_event(random_event(OP_REPORT, T0 + 64'd1000));
    send_event(random_event(OP_TICK, T0 + 64'd2000));
    wait_drained();
    program_settings(phase_cfg[0]);
    send_event(random_event(OP_NONE, T0));
    send_event(random_event(OP_PRESENT, 64'd0));
    for (int k = 0; k < 7; k++)
      send_event(random_event(OP_PRESENT, T0 + 64'(k) * 64'd25000000));
    send_event(random_event(OP_TICK, T0 + 64'd155000000));
    e = random_event(OP_REPORT, T0 + 64'd160000000);
    e.comp = 1'b1;
    send_event(e);
    e.comp = 1'b0; e.pid = '0; e.tgt_fps = '0; e.iv_ns = '1;
    e.at_ns = T0 + 64'd161000000;
    send_event(e);
    e.tgt_fps = 12'hFFF; e.at_ns = T0 + 64'd162000000;
    send_event(e);
    e.tgt_fps = 12'd300; e.pid = '1; e.iv_ns = '0; e.at_ns = T0 + 64'd163000000;
    send_event(e);
    send_event(random_event(OP_PRESENT, T0 + 64'd100000000));
    send_event(random_event(OP_PRESENT, T0 + 64'd260000000));
    send_event(random_event(OP_TICK, 64'd1000));
    send_event(random_event(OP_TICK, '1));
    e = random_event(OP_REPORT, T0 + 64'd3000000000);
    e.comp = 1'b0; e.pid = '1; e.iv_ns = '1;
    send_event(e);
    e.iv_ns = NS_MAX_INTERVAL; e.at_ns = T0 + 64'd3020000000;
    send_event(e);
    e.iv_ns = NS_MAX_INTERVAL + 64'd1; e.at_ns = T0 + 64'd3040000000;
    send_event(e);
    send_event(random_event(OP_TICK, T0 + 64'd3100000000));

    clock_ns = T0 + 64'd4000000000;
    app_pid  = 22'($urandom);
    gap      = 64'd16666666;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      program_settings(phase_cfg[ph]);
      src_idle_en  = (ph != NUM_PHASES - 1);
      sink_idle_en = (ph != NUM_PHASES - 1);
      if (ph == 1) begin
        src_idle_en = 1'b0;
        park_sink   = 1'b1;
      end
      sent = 0;
      while (sent < phase_items[ph]) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // steady cadence from one process, ticks and reports in between
          gap = 64'($urandom_range(4000000, 45000000));
          if ($urandom_range(0, 3) == 0) app_pid = 22'($urandom);
          len = $urandom_range(12, 40);
          for (int k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
              clock_ns = clock_ns + gap - 64'd2000000 + 64'($urandom_range(0, 4000000));
              e = random_event(OP_PRESENT, clock_ns);
            end else if (roll < 93) begin
              clock_ns = clock_ns + 64'($urandom_range(0, 20000000));
              e = random_event(OP_TICK, clock_ns);
            end else begin
              e = random_event(OP_REPORT, clock_ns);
              e.pid = app_pid;
              e.iv_ns = gap;
              e.tgt_fps = ($urandom_range(0, 4) == 0) ? 12'($urandom) :
                          12'($urandom_range(1, 300));
              e.comp = ($urandom_range(0, 4) == 0);
            end
            send_event(e);
            sent++;
          end
        end else if (kind < 8) begin
          // presents silent: reports carry the cadence
          clock_ns = clock_ns + 64'($urandom_range(500, 1500)) * 64'd1000000;
          gap = 64'($urandom_range(4000000, 45000000));
          len = $urandom_range(10, 24);
          for (int k = 0; k < len; k++) begin
            clock_ns = clock_ns + gap;
            if ($urandom_range(0, 2) != 0) begin
              e = random_event(OP_REPORT, clock_ns);
              e.pid = app_pid;
              e.iv_ns = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : gap;
              e.tgt_fps = ($urandom_range(0, 4) == 0) ? 12'($urandom) :
                          12'($urandom_range(1, 300));
              e.comp = ($urandom_range(0, 9) == 0);
            end else begin
              e = random_event(OP_TICK, clock_ns);
            end
            send_event(e);
            sent++;
          end
        end else begin
          // noise: any opcode, stray and backward timestamps
          len = $urandom_range(2, 6);
          for (int k = 0; k < len; k++) begin
            e = random_event(2'($urandom), clock_ns);
            case ($urandom_range(0, 3))
              0: e.at_ns = '0;
              1: e.at_ns = clock_ns - 64'($urandom_range(0, 1000000000));
              2: e.at_ns = {$urandom, $urandom};
              default: e.at_ns = clock_ns + 64'($urandom_range(0, 900000000));
            endcase
            if ($urandom_range(0, 3) == 0) clock_ns = e.at_ns;
            send_event(e);
            sent++;
          end
        end
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (sb.pending_decisions.size() != 0)
      $display("%0d decision words never arrived", sb.pending_decisions.size());
    if (sb.errors == 0 && sb.pending_decisions.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
